FILE: design/sst_pkg.sv
`timescale 1ns / 1ps
package sst_pkg;
	localparam int LenBits = 16;
	localparam int MantBits = 32;
	localparam logic [LenBits-1:0] LenMax = '1;
	localparam logic [MantBits-1:0] MantMax = '1;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_COMMENT = 3'd1;
	localparam logic [2:0] M_STRING = 3'd2;
	localparam logic [2:0] M_ESCAPE = 3'd3;
	localparam logic [2:0] M_IDENT = 3'd4;
	localparam logic [2:0] M_NUMBER = 3'd5;
	localparam logic [2:0] M_OPER = 3'd6;
	localparam logic [2:0] M_ERROR = 3'd7;

	localparam logic [1:0] K_CHAR = 2'd0;
	localparam logic [1:0] K_END = 2'd1;
	localparam logic [1:0] K_ERR = 2'd2;

	localparam logic [2:0] C_NUMBER = 3'd0;
	localparam logic [2:0] C_STRING = 3'd1;
	localparam logic [2:0] C_KEYWORD = 3'd2;
	localparam logic [2:0] C_VARIABLE = 3'd3;
	localparam logic [2:0] C_PUNCT = 3'd4;
	localparam logic [2:0] C_OPER = 3'd5;

	typedef struct packed {
		logic [1:0] record_kind;
		logic [2:0] token_class;
		logic [7:0] char_value;
		logic [LenBits-1:0] token_length;
		logic [2:0] keyword_index;
		logic [MantBits-1:0] mantissa;
		logic [7:0] fraction_digits;
		logic error_code;
		logic last;
	} rec_t;

	// Up to three records per input beat.
	typedef struct packed {
		logic [1:0] cnt;
		rec_t r0;
		rec_t r1;
		rec_t r2;
	} bundle_t;

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [47:0] s;
		unique case (k)
			3'd0: s = {"if", 32'd0};
			3'd1: s = {"then", 16'd0};
			3'd2: s = {"let", 24'd0};
			3'd3: s = {"else", 16'd0};
			3'd4: s = "lambda";
			3'd5: s = {"true", 16'd0};
			3'd6: s = {"false", 8'd0};
			default: s = {"js", 32'd0};
		endcase
		kw_char = (p < 3'd6) ? s[8'(47 - 8 * int'(p)) -: 8] : 8'd0;
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		unique case (k)
			3'd0: kw_len = 3'd2;
			3'd1: kw_len = 3'd4;
			3'd2: kw_len = 3'd3;
			3'd3: kw_len = 3'd4;
			3'd4: kw_len = 3'd6;
			3'd5: kw_len = 3'd4;
			3'd6: kw_len = 3'd5;
			default: kw_len = 3'd2;
		endcase
	endfunction
endpackage

FILE: design/streaming_source_tokenizer_core.sv
`timescale 1ns / 1ps
// The tokenizer takes one input beat per cycle whenever its four-entry result queue has room;
// each beat yields zero to three output beats, leaving at one per cycle unless stalled, so
// a run of punctuation or token ends drains slower than it arrives; the queue sets the stall.
module streaming_source_tokenizer_core
	import sst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [7:0] char_in,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] record_kind,
	output logic [2:0] token_class,
	output logic [7:0] char_value,
	output logic [15:0] token_length,
	output logic [2:0] keyword_index,
	output logic [31:0] mantissa,
	output logic [7:0] fraction_digits,
	output logic error_code,
	output logic last
);
	logic push, full, in_ok;
	bundle_t bundle;
	rec_t rec;

	assign in_stall = full;
	assign in_ok = in_valid && !full;

	sst_front u_front (.clk, .arst_n, .in_ok, .action, .char_in, .push, .bundle);
	sst_back u_back (.clk, .arst_n, .push, .bundle, .full, .out_stall, .out_valid,
		.out_rec(rec));

	assign record_kind = rec.record_kind;
	assign token_class = rec.token_class;
	assign char_value = rec.char_value;
	assign token_length = rec.token_length;
	assign keyword_index = rec.keyword_index;
	assign mantissa = rec.mantissa;
	assign fraction_digits = rec.fraction_digits;
	assign error_code = rec.error_code;
	assign last = rec.last;

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == K_ERR |-> token_length == '0 && last)
		else $error("error beat carries payload");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overrun");
	a_kw_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keyword_index != 3'd0 |-> token_class == C_KEYWORD)
		else $error("keyword index outside keyword record");
endmodule

FILE: design/sst_front.sv
`timescale 1ns / 1ps
module sst_front
	import sst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ok,
	input logic action,
	input logic [7:0] char_in,
	output logic push,
	output bundle_t bundle
);
	logic [2:0] mode_q;
	logic dot_q;
	logic [LenBits-1:0] len_q;
	logic [7:0] cand_q;
	logic [MantBits-1:0] mant_q;
	logic [7:0] frac_q;

	logic [2:0] m_n;
	logic dot_n;
	logic [LenBits-1:0] len_n;
	logic [7:0] cand_n;
	logic [MantBits-1:0] mant_n;
	logic [7:0] frac_n;
	logic [1:0] n;
	rec_t r [3];

	function automatic logic is_dig(input logic [7:0] c);
		is_dig = c >= "0" && c <= "9";
	endfunction
	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic logic is_oper(input logic [7:0] c);
		is_oper = c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "="
			|| c == "&" || c == "|" || c == "<" || c == ">" || c == "!";
	endfunction
	function automatic logic is_punct(input logic [7:0] c);
		is_punct = c == "," || c == ";" || c == "(" || c == ")" || c == "{" || c == "}"
			|| c == "[" || c == "]";
	endfunction
	function automatic logic is_ident(input logic [7:0] c);
		is_ident = is_alpha(c) || is_dig(c) || c == "_" || c == "?" || c == "!" || c == "-"
			|| c == "<" || c == ">" || c == "=";
	endfunction
	function automatic logic [LenBits-1:0] bump(input logic [LenBits-1:0] l);
		bump = (l == LenMax) ? l : l + 1'b1;
	endfunction

	always_comb begin
		logic [7:0] c;
		logic [LenBits-1:0] l0;
		logic [7:0] cd;
		logic [MantBits+3:0] prod;
		logic kwhit;
		logic [2:0] kwi;
		rec_t e, z;
		logic do_end, do_idle;
		c = char_in;
		z = '0;
		l0 = '0;
		cd = '0;
		prod = '0;
		m_n = mode_q; dot_n = dot_q; len_n = len_q; cand_n = cand_q;
		mant_n = mant_q; frac_n = frac_q;
		n = 2'd0;
		r[0] = z; r[1] = z; r[2] = z;
		do_end = 1'b0; do_idle = 1'b0;
		// End record of the current token.
		kwhit = 1'b0; kwi = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (cand_q[k] && len_q == LenBits'(kw_len(3'(k)))) begin
				kwhit = 1'b1; kwi = 3'(k);
			end
		end
		e = z;
		e.record_kind = K_END;
		e.token_length = len_q;
		if (mode_q == M_NUMBER) begin
			e.token_class = C_NUMBER;
			e.mantissa = mant_q;
			e.fraction_digits = frac_q;
		end else if (mode_q == M_OPER) begin
			e.token_class = C_OPER;
		end else if (kwhit) begin
			e.token_class = C_KEYWORD;
			e.keyword_index = kwi;
		end else begin
			e.token_class = C_VARIABLE;
		end
		if (action) begin
			if (mode_q == M_IDENT || mode_q == M_NUMBER || mode_q == M_OPER) begin
				r[0] = e; n = 2'd1;
			end else if (mode_q == M_STRING || mode_q == M_ESCAPE) begin
				r[0] = z; r[0].record_kind = K_ERR; r[0].error_code = 1'b1; n = 2'd1;
			end
			m_n = M_IDLE; dot_n = 1'b0; len_n = '0; cand_n = '1; mant_n = '0; frac_n = '0;
		end else begin
			unique case (mode_q)
				M_IDLE: do_idle = 1'b1;
				M_COMMENT: if (c == 8'h0a) m_n = M_IDLE;
				M_STRING: begin
					if (c == "\\") m_n = M_ESCAPE;
					else if (c == "\"") begin
						r[0] = z; r[0].record_kind = K_END; r[0].token_class = C_STRING;
						r[0].token_length = len_q; n = 2'd1;
						m_n = M_IDLE; dot_n = 1'b0; len_n = '0; cand_n = '1;
						mant_n = '0; frac_n = '0;
					end else begin
						len_n = bump(len_q);
						r[0] = z; r[0].token_class = C_STRING; r[0].char_value = c;
						r[0].token_length = len_n; n = 2'd1;
					end
				end
				M_ESCAPE: begin
					len_n = bump(len_q);
					r[0] = z; r[0].token_class = C_STRING; r[0].char_value = c;
					r[0].token_length = len_n; n = 2'd1;
					m_n = M_STRING;
				end
				M_IDENT: if (is_ident(c)) begin
					for (int k = 0; k < 8; k++)
						if (len_q >= LenBits'(kw_len(3'(k)))
							|| kw_char(3'(k), len_q[2:0]) != c) cand_n[k] = 1'b0;
					len_n = bump(len_q);
					r[0] = z; r[0].token_class = C_VARIABLE; r[0].char_value = c;
					r[0].token_length = len_n; n = 2'd1;
				end else do_end = 1'b1;
				M_NUMBER: if (is_dig(c) || (c == "." && !dot_q)) begin
					if (c == ".") dot_n = 1'b1;
					else begin
						cd = c - "0";
						prod = {mant_q, 3'b0} + {2'b0, mant_q, 1'b0} + (MantBits+4)'(cd);
						mant_n = (prod[MantBits+3:MantBits] != 0) ? MantMax
							: prod[MantBits-1:0];
						if (dot_q && frac_q != 8'hff) frac_n = frac_q + 1'b1;
					end
					len_n = bump(len_q);
					r[0] = z; r[0].token_class = C_NUMBER; r[0].char_value = c;
					r[0].token_length = len_n; n = 2'd1;
				end else do_end = 1'b1;
				M_OPER: if (is_oper(c)) begin
					len_n = bump(len_q);
					r[0] = z; r[0].token_class = C_OPER; r[0].char_value = c;
					r[0].token_length = len_n; n = 2'd1;
				end else do_end = 1'b1;
				default: ;
			endcase
			if (do_end) begin
				r[0] = e; n = 2'd1; do_idle = 1'b1;
			end
			if (do_idle) begin
				m_n = M_IDLE;
				if (c == " " || c == 8'h09 || c == 8'h0a) begin
				end else if (c == "#") m_n = M_COMMENT;
				else begin
					dot_n = 1'b0; cand_n = '1; mant_n = '0; frac_n = '0;
					l0 = LenBits'(1);
					if (c == "\"") begin
						m_n = M_STRING; len_n = '0;
					end else begin
						len_n = l0;
						r[n] = z; r[n].char_value = c; r[n].token_length = l0;
						if (is_dig(c)) begin
							m_n = M_NUMBER; r[n].token_class = C_NUMBER;
							mant_n = MantBits'(c - "0");
						end else if (is_alpha(c) || c == "_") begin
							m_n = M_IDENT; r[n].token_class = C_VARIABLE;
							for (int k = 0; k < 8; k++)
								if (kw_char(3'(k), 3'd0) != c) cand_n[k] = 1'b0;
						end else if (is_punct(c)) begin
							r[n].token_class = C_PUNCT;
							r[n+1] = z; r[n+1].record_kind = K_END;
							r[n+1].token_class = C_PUNCT; r[n+1].token_length = l0;
							n = n + 2'd1;
						end else if (is_oper(c)) begin
							m_n = M_OPER; r[n].token_class = C_OPER;
						end else begin
							m_n = M_ERROR; len_n = '0;
							r[n] = z; r[n].record_kind = K_ERR;
						end
						n = n + 2'd1;
					end
				end
			end
		end
		if (n != 2'd0) r[n-1].last = 1'b1;
	end

	assign push = in_ok && n != 2'd0;
	assign bundle = '{cnt: n, r0: r[0], r1: r[1], r2: r[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; dot_q <= 1'b0; len_q <= '0; cand_q <= '1;
			mant_q <= '0; frac_q <= '0;
		end else if (in_ok) begin
			mode_q <= m_n; dot_q <= dot_n; len_q <= len_n; cand_q <= cand_n;
			mant_q <= mant_n; frac_q <= frac_n;
		end
	end
endmodule

FILE: design/sst_back.sv
`timescale 1ns / 1ps
module sst_back
	import sst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input bundle_t bundle,
	output logic full,
	input logic out_stall,
	output logic out_valid,
	output rec_t out_rec
);
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [1:0] sub_q;
	bundle_t mem_q [4];
	bundle_t head;
	logic pop;

	assign head = mem_q[rp_q];
	assign out_valid = cnt_q != 3'd0;
	always_comb begin
		unique case (sub_q)
			2'd0: out_rec = head.r0;
			2'd1: out_rec = head.r1;
			default: out_rec = head.r2;
		endcase
	end
	assign full = cnt_q[2];
	assign pop = out_valid && !out_stall && (sub_q + 2'd1 == head.cnt);

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
			if (out_valid && !out_stall) sub_q <= pop ? 2'd0 : sub_q + 2'd1;
		end
	end
endmodule

FILE: verif/tb_streaming_source_tokenizer_core.sv
`timescale 1ns / 1ps
module tb_streaming_source_tokenizer_core;
	import sst_pkg::*;

	localparam int UNTYPED = -1;
	localparam int NO_RESULT = 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 175;

	typedef struct {
		logic act;
		logic [7:0] ch;
		int want;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [7:0] char_in = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] record_kind;
	logic [2:0] token_class;
	logic [7:0] char_value;
	logic [15:0] token_length;
	logic [2:0] keyword_index;
	logic [31:0] mantissa;
	logic [7:0] fraction_digits;
	logic error_code;
	logic last;

	streaming_source_tokenizer_core uut (.*);

	always #2 clk = ~clk;

	beat_t source_beats[$];
	int typed_kinds[$];
	rec_t pending_records[$];
	int errors = 0;
	int cycles = 0;
	int records_seen = 0;
	int items_sent = 0;
	int keywords_seen = 0;
	bit hold_req = 1'b0;
	bit quiet = 1'b0;

	// Tokenizer state as tracked by the testbench.
	logic [2:0] lex_mode = M_IDLE;
	logic dot_seen = 1'b0;
	logic [15:0] tok_len = '0;
	logic [7:0] kw_alive = '1;
	logic [31:0] digits_value = '0;
	logic [7:0] frac_count = '0;
	int beat_records;

	string keyword_names[8] = '{"if", "then", "let", "else", "lambda", "true", "false", "js"};

	function automatic bit is_numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_op_char(logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "%", "=", "&", "|", "<", ">", "!": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_ident_tail(logic [7:0] c);
		case (c)
			"_", "?", "!", "-", "<", ">", "=": return 1'b1;
			default: return is_letter(c) || is_numeral(c);
		endcase
	endfunction

	function automatic bit is_punct(logic [7:0] c);
		case (c)
			",", ";", "(", ")", "{", "}", "[", "]": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic add_record(logic [1:0] kind, logic [2:0] cls, logic [7:0] ch, logic [15:0] len,
			logic [2:0] kwi, logic [31:0] mant, logic [7:0] frac, logic err);
		rec_t r;
		r.record_kind = kind;
		r.token_class = cls;
		r.char_value = ch;
		r.token_length = len;
		r.keyword_index = kwi;
		r.mantissa = mant;
		r.fraction_digits = frac;
		r.error_code = err;
		r.last = 1'b0;
		pending_records.insert(pending_records.size(), r);
		beat_records++;
	endtask

	task automatic clear_token();
		dot_seen = 1'b0;
		tok_len = '0;
		kw_alive = '1;
		digits_value = '0;
		frac_count = '0;
	endtask

	task automatic grow_length();
		if (tok_len != LenMax)
			tok_len++;
	endtask

	task automatic take_ident_char(logic [7:0] c);
		for (int k = 0; k < 8; k++)
			if (kw_alive[k] && (tok_len >= keyword_names[k].len() || keyword_names[k][tok_len] != c))
				kw_alive[k] = 1'b0;
		grow_length();
	endtask

	task automatic take_number_char(logic [7:0] c);
		logic [63:0] wide;
		if (c == ".") begin
			dot_seen = 1'b1;
		end else begin
			wide = 64'(digits_value) * 10 + 64'(c - "0");
			digits_value = (wide > 64'(MantMax)) ? MantMax : wide[31:0];
			if (dot_seen && frac_count != 8'hFF)
				frac_count++;
		end
		grow_length();
	endtask

	task automatic close_token();
		if (lex_mode == M_NUMBER) begin
			add_record(K_END, C_NUMBER, 0, tok_len, 0, digits_value, frac_count, 0);
		end else if (lex_mode == M_OPER) begin
			add_record(K_END, C_OPER, 0, tok_len, 0, 0, 0, 0);
		end else begin
			for (int k = 0; k < 8; k++)
				if (kw_alive[k] && keyword_names[k].len() == tok_len) begin
					add_record(K_END, C_KEYWORD, 0, tok_len, 3'(k), 0, 0, 0);
					return;
				end
			add_record(K_END, C_VARIABLE, 0, tok_len, 0, 0, 0, 0);
		end
	endtask

	task automatic start_token(logic [7:0] c);
		lex_mode = M_IDLE;
		if (c == " " || c == "\t" || c == "\n")
			return;
		if (c == "#") begin
			lex_mode = M_COMMENT;
			return;
		end
		clear_token();
		if (c == "\"") begin
			lex_mode = M_STRING;
		end else if (is_numeral(c)) begin
			lex_mode = M_NUMBER;
			take_number_char(c);
			add_record(K_CHAR, C_NUMBER, c, tok_len, 0, 0, 0, 0);
		end else if (is_letter(c) || c == "_") begin
			lex_mode = M_IDENT;
			take_ident_char(c);
			add_record(K_CHAR, C_VARIABLE, c, tok_len, 0, 0, 0, 0);
		end else if (is_punct(c)) begin
			add_record(K_CHAR, C_PUNCT, c, 1, 0, 0, 0, 0);
			add_record(K_END, C_PUNCT, 0, 1, 0, 0, 0, 0);
		end else if (is_op_char(c)) begin
			lex_mode = M_OPER;
			grow_length();
			add_record(K_CHAR, C_OPER, c, tok_len, 0, 0, 0, 0);
		end else begin
			lex_mode = M_ERROR;
			add_record(K_ERR, 0, 0, 0, 0, 0, 0, 0);
		end
	endtask

	task automatic tokenize_beat(logic act, logic [7:0] c);
		beat_records = 0;
		if (act) begin
			if (lex_mode == M_IDENT || lex_mode == M_NUMBER || lex_mode == M_OPER)
				close_token();
			else if (lex_mode == M_STRING || lex_mode == M_ESCAPE)
				add_record(K_ERR, 0, 0, 0, 0, 0, 0, 1);
			lex_mode = M_IDLE;
			clear_token();
		end else begin
			case (lex_mode)
				M_IDLE: start_token(c);
				M_COMMENT: if (c == "\n") lex_mode = M_IDLE;
				M_STRING: begin
					if (c == "\\") begin
						lex_mode = M_ESCAPE;
					end else if (c == "\"") begin
						add_record(K_END, C_STRING, 0, tok_len, 0, 0, 0, 0);
						lex_mode = M_IDLE;
						clear_token();
					end else begin
						grow_length();
						add_record(K_CHAR, C_STRING, c, tok_len, 0, 0, 0, 0);
					end
				end
				M_ESCAPE: begin
					grow_length();
					add_record(K_CHAR, C_STRING, c, tok_len, 0, 0, 0, 0);
					lex_mode = M_STRING;
				end
				M_IDENT: begin
					if (is_ident_tail(c)) begin
						take_ident_char(c);
						add_record(K_CHAR, C_VARIABLE, c, tok_len, 0, 0, 0, 0);
					end else begin
						close_token();
						start_token(c);
					end
				end
				M_NUMBER: begin
					if (is_numeral(c) || (c == "." && !dot_seen)) begin
						take_number_char(c);
						add_record(K_CHAR, C_NUMBER, c, tok_len, 0, 0, 0, 0);
					end else begin
						close_token();
						start_token(c);
					end
				end
				M_OPER: begin
					if (is_op_char(c)) begin
						grow_length();
						add_record(K_CHAR, C_OPER, c, tok_len, 0, 0, 0, 0);
					end else begin
						close_token();
						start_token(c);
					end
				end
				default: ;
			endcase
		end
		if (beat_records > 0)
			pending_records[pending_records.size() - 1].last = 1'b1;
	endtask

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// Input acceptance feeds the tracker first, then the output beat is compared.
	always @(posedge clk) begin
		int first;
		int want;
		rec_t w;
		if (arst_n) begin
			cycles++;
			if (in_valid && !in_stall) begin
				first = pending_records.size();
				tokenize_beat(action, char_in);
				want = typed_kinds.pop_front();
				if (want != UNTYPED) begin
					if (first == pending_records.size()) begin
						if (want != NO_RESULT)
							report("directed beat record count", 0, 1);
					end else if (pending_records[first].record_kind != want) begin
						report("directed beat first kind", pending_records[first].record_kind, want);
					end
				end
			end
			if (out_valid && !out_stall) begin
				records_seen++;
				if (pending_records.size() == 0) begin
					report("record with nothing pending, kind", record_kind, 0);
				end else begin
					w = pending_records.pop_front();
					if (w.record_kind == K_END && w.token_class == C_KEYWORD)
						keywords_seen++;
					if (record_kind !== w.record_kind) report("record_kind", record_kind, w.record_kind);
					if (token_class !== w.token_class) report("token_class", token_class, w.token_class);
					if (char_value !== w.char_value) report("char_value", char_value, w.char_value);
					if (token_length !== w.token_length)
						report("token_length", token_length, w.token_length);
					if (keyword_index !== w.keyword_index)
						report("keyword_index", keyword_index, w.keyword_index);
					if (mantissa !== w.mantissa) report("mantissa", mantissa, w.mantissa);
					if (fraction_digits !== w.fraction_digits)
						report("fraction_digits", fraction_digits, w.fraction_digits);
					if (error_code !== w.error_code) report("error_code", error_code, w.error_code);
					if (last !== w.last) report("last", last, w.last);
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAIL streaming_source_tokenizer_core");
				$finish;
			end
		end
	end

	// Receiver: random stalls per beat, with one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_req = 1'b0;
			end
			g = quiet ? 0 : $urandom_range(0, 8);
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic queue_beat(logic act, logic [7:0] c, int want);
		beat_t b;
		b.act = act;
		b.ch = c;
		b.want = want;
		source_beats.insert(source_beats.size(), b);
	endtask

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_beat(1'b0, s[i], UNTYPED);
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	task automatic queue_random_token();
		int n;
		case ($urandom_range(0, 9))
			0: queue_text(keyword_names[$urandom_range(0, 7)]);
			1: begin
				queue_beat(1'b0, pick("abcxyzQ_"), UNTYPED);
				n = $urandom_range(0, 5);
				repeat (n) queue_beat(1'b0, pick("az09_?!-<>=Tk"), UNTYPED);
			end
			2: begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
				repeat (n) queue_beat(1'b0, 8'("0") + 8'($urandom_range(0, 9)), UNTYPED);
				if ($urandom_range(0, 1)) begin
					queue_beat(1'b0, ".", UNTYPED);
					repeat ($urandom_range(0, 4)) queue_beat(1'b0, 8'("0") + 8'($urandom_range(0, 9)),
						UNTYPED);
				end
			end
			3: begin
				queue_beat(1'b0, "\"", UNTYPED);
				n = $urandom_range(0, 5);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0)
						queue_beat(1'b0, "\\", UNTYPED);
					queue_beat(1'b0, 8'($urandom_range(0, 255)), UNTYPED);
				end
				queue_beat(1'b0, "\"", UNTYPED);
			end
			4: repeat ($urandom_range(1, 3)) queue_beat(1'b0, pick("+-*/%=&|<>!"), UNTYPED);
			5: repeat ($urandom_range(1, 4)) queue_beat(1'b0, pick(",;(){}[]"), UNTYPED);
			6: queue_beat(1'b0, pick(" \t\n"), UNTYPED);
			7: begin
				queue_beat(1'b0, "#", UNTYPED);
				repeat ($urandom_range(0, 4)) queue_beat(1'b0, 8'($urandom_range(0, 255)), UNTYPED);
				queue_beat(1'b0, "\n", UNTYPED);
			end
			8: queue_beat(1'b0, 8'($urandom_range(0, 255)), UNTYPED);
			default: queue_beat(1'b1, 8'($urandom_range(0, 255)), UNTYPED);
		endcase
		if ($urandom_range(0, 1))
			queue_beat(1'b0, " ", UNTYPED);
	endtask

	initial begin
		beat_t directed[] = '{
			'{1'b0, "i", K_CHAR}, '{1'b0, "f", UNTYPED}, '{1'b0, " ", K_END},
			'{1'b0, "9", K_CHAR}, '{1'b0, "0", UNTYPED}, '{1'b0, ".", UNTYPED},
			'{1'b0, "5", UNTYPED}, '{1'b0, ".", K_END}, '{1'b0, "a", NO_RESULT},
			'{1'b1, 8'hFF, NO_RESULT}, '{1'b0, "\"", NO_RESULT}, '{1'b0, "x", K_CHAR},
			'{1'b0, "\\", NO_RESULT}, '{1'b0, "\"", K_CHAR}, '{1'b0, "\"", K_END},
			'{1'b0, ",", K_CHAR}, '{1'b0, "+", K_CHAR}, '{1'b0, "=", UNTYPED},
			'{1'b0, 8'hFF, K_END}, '{1'b1, 8'h00, NO_RESULT}, '{1'b0, "#", NO_RESULT},
			'{1'b0, "z", NO_RESULT}, '{1'b0, "\n", NO_RESULT}, '{1'b0, "\"", NO_RESULT},
			'{1'b0, "q", K_CHAR}, '{1'b1, 8'h00, K_ERR}, '{1'b1, 8'h00, NO_RESULT}
		};
		beat_t b;
		int g;
		int waited;
		foreach (directed[i])
			source_beats.insert(source_beats.size(), directed[i]);
		while (source_beats.size() < directed.size() + RANDOM_ITEMS)
			queue_random_token();
		queue_beat(1'b1, 8'h00, UNTYPED);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (source_beats.size() > 0) begin
			b = source_beats.pop_front();
			if (items_sent == 60)
				hold_req = 1'b1;
			quiet = (items_sent >= 120 && items_sent < 160);
			g = quiet ? 0 : $urandom_range(0, 8);
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			typed_kinds.insert(typed_kinds.size(), b.want);
			in_valid <= 1'b1;
			action <= b.act;
			char_in <= b.ch;
			do @(posedge clk); while (in_stall);
			items_sent++;
		end
		in_valid <= 1'b0;
		waited = 0;
		while (pending_records.size() > 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (pending_records.size() > 0)
			report("records never delivered", 0, pending_records.size());
		$display("Sent %0d source beats (directed cases plus random token streams)", items_sent);
		$display("Checked %0d records, %0d keyword ends, one long output hold-off",
			records_seen, keywords_seen);
		if (errors == 0)
			$display("PASS streaming_source_tokenizer_core");
		else
			$display("FAIL streaming_source_tokenizer_core");
		$finish;
	end
endmodule

FILE: filelist.f
design/sst_pkg.sv
design/sst_front.sv
design/sst_back.sv
design/streaming_source_tokenizer_core.sv
verif/tb_streaming_source_tokenizer_core.sv
